// File: src/shape_vertex_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// Shape vertex generator assertion macros
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHAPE_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define SHAPE_VERTEX_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SVG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/svg_pkg.sv
// ----------------------------------------------------------------------------
// Shape vertex generator package
// Widths, opcodes, fixed-point constants and shared helper functions.
// ----------------------------------------------------------------------------
package svg_pkg;

    localparam int COORD_W       = 24;
    localparam int FRAC_BITS     = 8;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_W       = 18;
    localparam int STRIDE_W      = 5;
    localparam int IDX_W         = 3;
    localparam int OFS_W         = 7;
    localparam int OP_W          = 3;
    localparam int NVERT         = 6;
    localparam int ATAN_COUNT    = 24;

    localparam int CORDIC_ITERS = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

    localparam logic [OP_W-1:0] OP_DIRECT    = 3'd0;
    localparam logic [OP_W-1:0] OP_OFFSETS   = 3'd1;
    localparam logic [OP_W-1:0] OP_ROTATED   = 3'd2;
    localparam logic [OP_W-1:0] OP_RIGHT     = 3'd3;
    localparam logic [OP_W-1:0] OP_ROT_RIGHT = 3'd4;
    localparam logic [OP_W-1:0] OP_EQUI      = 3'd5;
    localparam logic [OP_W-1:0] OP_RECT      = 3'd6;

    localparam logic [IDX_W-1:0] TRI_LAST  = 3'd2;
    localparam logic [IDX_W-1:0] RECT_LAST = 3'd5;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd2;

    localparam int DIFF_W = COORD_W + 2;
    localparam int GAIN_W = 17;
    localparam int CX_W   = DIFF_W + GAIN_W + 2;
    localparam int Z_W    = 26;
    localparam int RX_W   = CX_W - 16;
    localparam int SUM_W  = RX_W + 1;
    localparam int H_W    = COORD_W + 1;
    localparam int HPROD_W = COORD_W + GAIN_W;
    localparam int MAG_W  = ANGLE_W;
    localparam int RED_W  = ((ANGLE_W > FRAC_BITS + 10) ? ANGLE_W : FRAC_BITS + 10) + 2;
    localparam int ZSHIFT = 16 - FRAC_BITS;

    localparam int FULL_TURN    = 360 << FRAC_BITS;
    localparam int HALF_TURN    = 180 << FRAC_BITS;
    localparam int QUARTER_TURN = 90 << FRAC_BITS;

    localparam int      RECIP_SH = 32;
    localparam longint  RECIP    = (longint'(1) << RECIP_SH) / FULL_TURN;
    localparam int      RECIP_W  = $clog2(RECIP + 1);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    localparam logic signed [RED_W-1:0] FULL_S    = RED_W'(FULL_TURN);
    localparam logic signed [RED_W-1:0] HALF_S    = RED_W'(HALF_TURN);
    localparam logic signed [RED_W-1:0] QUARTER_S = RED_W'(QUARTER_TURN);

    localparam logic signed [GAIN_W-1:0] INV_GAIN_C   = 17'sd39797;
    localparam logic signed [GAIN_W-1:0] SQRT3_HALF_C = 17'sd56756;

    localparam logic signed [SUM_W-1:0] SUM_HI =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO =
        {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [H_W-1:0]     h;
    } side_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [Z_W-1:0] atan_q16(input int i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SUM_HI)
            r = {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < SUM_LO)
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

// File: src/svg_if.sv
// ----------------------------------------------------------------------------
// Shape vertex generator channel interfaces
// Request channel and vertex channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface svg_req_if;
    logic                               valid;
    logic                               ready;
    logic [svg_pkg::OP_W-1:0]           opcode;
    logic signed [svg_pkg::COORD_W-1:0] pos_x;
    logic signed [svg_pkg::COORD_W-1:0] pos_y;
    logic signed [svg_pkg::COORD_W-1:0] a_x;
    logic signed [svg_pkg::COORD_W-1:0] a_y;
    logic signed [svg_pkg::COORD_W-1:0] b_x;
    logic signed [svg_pkg::COORD_W-1:0] b_y;
    logic signed [svg_pkg::ANGLE_W-1:0] angle;

    modport source (output valid, opcode, pos_x, pos_y, a_x, a_y, b_x, b_y, angle,
                    input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, a_x, a_y, b_x, b_y, angle,
                    output ready);
endinterface

interface svg_vtx_if;
    logic                               valid;
    logic                               ready;
    logic signed [svg_pkg::COORD_W-1:0] vertex_x;
    logic signed [svg_pkg::COORD_W-1:0] vertex_y;
    logic [svg_pkg::IDX_W-1:0]          vertex_index;
    logic [svg_pkg::OFS_W-1:0]          word_offset;
    logic                               last;
    logic                               size_error;

    modport source (output valid, vertex_x, vertex_y, vertex_index, word_offset, last,
                    size_error, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_index, word_offset, last,
                    size_error, output ready);
endinterface

// File: src/svg_cordic.sv
// ----------------------------------------------------------------------------
// Dual CORDIC rotator
// Pipelined rotation-mode CORDIC, one iteration per stage, two vectors
// sharing one angle, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module svg_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  svg_pkg::side_t                    in_side,
    input  logic signed [svg_pkg::CX_W-1:0]   in_xa,
    input  logic signed [svg_pkg::CX_W-1:0]   in_ya,
    input  logic signed [svg_pkg::CX_W-1:0]   in_xb,
    input  logic signed [svg_pkg::CX_W-1:0]   in_yb,
    input  logic signed [svg_pkg::Z_W-1:0]    in_z,
    output logic                              out_valid,
    output svg_pkg::side_t                    out_side,
    output logic signed [svg_pkg::CX_W-1:0]   out_xa,
    output logic signed [svg_pkg::CX_W-1:0]   out_ya,
    output logic signed [svg_pkg::CX_W-1:0]   out_xb,
    output logic signed [svg_pkg::CX_W-1:0]   out_yb
);
    import svg_pkg::*;

    logic                  valid_reg [CORDIC_ITERS];
    side_t                 side_reg  [CORDIC_ITERS];
    logic signed [CX_W-1:0] xa_reg   [CORDIC_ITERS];
    logic signed [CX_W-1:0] ya_reg   [CORDIC_ITERS];
    logic signed [CX_W-1:0] xb_reg   [CORDIC_ITERS];
    logic signed [CX_W-1:0] yb_reg   [CORDIC_ITERS];
    logic signed [Z_W-1:0]  z_reg    [CORDIC_ITERS];

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_stage
        logic                   v_in;
        side_t                  s_in;
        logic signed [CX_W-1:0] xa_in, ya_in, xb_in, yb_in;
        logic signed [Z_W-1:0]  z_in;
        logic signed [CX_W-1:0] xa_next, ya_next, xb_next, yb_next;
        logic signed [Z_W-1:0]  z_next;

        if (i == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign s_in  = in_side;
            assign xa_in = in_xa;
            assign ya_in = in_ya;
            assign xb_in = in_xb;
            assign yb_in = in_yb;
            assign z_in  = in_z;
        end
        else
        begin : g_rest
            assign v_in  = valid_reg[i-1];
            assign s_in  = side_reg[i-1];
            assign xa_in = xa_reg[i-1];
            assign ya_in = ya_reg[i-1];
            assign xb_in = xb_reg[i-1];
            assign yb_in = yb_reg[i-1];
            assign z_in  = z_reg[i-1];
        end

        always_comb
        begin
            if (!z_in[Z_W-1])
            begin
                xa_next = xa_in - (ya_in >>> i);
                ya_next = ya_in + (xa_in >>> i);
                xb_next = xb_in - (yb_in >>> i);
                yb_next = yb_in + (xb_in >>> i);
                z_next  = z_in - atan_q16(i);
            end
            else
            begin
                xa_next = xa_in + (ya_in >>> i);
                ya_next = ya_in - (xa_in >>> i);
                xb_next = xb_in + (yb_in >>> i);
                yb_next = yb_in - (xb_in >>> i);
                z_next  = z_in + atan_q16(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= s_in;
                xa_reg[i]   <= xa_next;
                ya_reg[i]   <= ya_next;
                xb_reg[i]   <= xb_next;
                yb_reg[i]   <= yb_next;
                z_reg[i]    <= z_next;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_ITERS-1];
    assign out_side  = side_reg[CORDIC_ITERS-1];
    assign out_xa    = xa_reg[CORDIC_ITERS-1];
    assign out_ya    = ya_reg[CORDIC_ITERS-1];
    assign out_xb    = xb_reg[CORDIC_ITERS-1];
    assign out_yb    = yb_reg[CORDIC_ITERS-1];

endmodule

// File: src/shape_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// Shape vertex generator
// Turns a request into its triangle or rectangle vertices, rotating via CORDIC.
// ----------------------------------------------------------------------------
// A request enters a fully pipelined datapath (angle reduction, gain scaling,
// CORDIC_STAGES rotation stages, rounding and saturation) that can take a new
// request every cycle unless the busy vertex serializer holds the pipeline. The
// vertex serializer at the end sends one vertex per cycle while vtx.ready is
// high, so a triangle is sent as three vertices and a rectangle as six; that
// serializer sets the sustained rate. Opcode 7 yields no vertex.
module shape_vertex_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [svg_pkg::STRIDE_W-1:0]  cfg_wdata,
    svg_req_if.sink                       req,
    svg_vtx_if.source                     vtx
);
    import svg_pkg::*;

    logic adv;
    logic [STRIDE_W-1:0] stride_reg;

    // ---- stage 1: angle magnitude, difference vectors
    logic                     s1_valid_reg;
    side_t                    s1_side_reg;
    logic [MAG_W-1:0]         s1_mag_reg;
    logic                     s1_neg_reg;
    logic signed [DIFF_W-1:0] s1_dax_reg, s1_day_reg, s1_dbx_reg, s1_dby_reg;

    logic signed [ANGLE_W:0]  ang_ext, ang_abs;
    logic signed [DIFF_W-1:0] dax, day, dbx, dby;
    side_t                    side_in;

    always_comb
    begin
        ang_ext = {req.angle[ANGLE_W-1], req.angle};
        ang_abs = ang_ext[ANGLE_W] ? -ang_ext : ang_ext;
        dax = '0;
        day = '0;
        dbx = '0;
        dby = '0;
        if (req.opcode == OP_ROTATED)
        begin
            dax = DIFF_W'(req.a_x) - DIFF_W'(req.pos_x);
            day = DIFF_W'(req.a_y) - DIFF_W'(req.pos_y);
            dbx = DIFF_W'(req.b_x) - DIFF_W'(req.pos_x);
            dby = DIFF_W'(req.b_y) - DIFF_W'(req.pos_y);
        end
        else if (req.opcode == OP_ROT_RIGHT)
        begin
            day = DIFF_W'(req.a_y);
            dbx = DIFF_W'(req.a_x);
        end
        side_in.op = req.opcode;
        side_in.px = req.pos_x;
        side_in.py = req.pos_y;
        side_in.ax = req.a_x;
        side_in.ay = req.a_y;
        side_in.bx = req.b_x;
        side_in.by = req.b_y;
        side_in.h  = '0;
    end

    // ---- stage 2: quotient estimate, equilateral height product
    logic                     s2_valid_reg;
    side_t                    s2_side_reg;
    logic [MAG_W-1:0]         s2_mag_reg, s2_q_reg;
    logic                     s2_neg_reg;
    logic signed [DIFF_W-1:0] s2_dax_reg, s2_day_reg, s2_dbx_reg, s2_dby_reg;
    logic signed [HPROD_W-1:0] s2_hprod_reg;

    logic [MAG_W+RECIP_W-1:0] q_prod;
    logic signed [HPROD_W-1:0] h_prod;

    always_comb
    begin
        q_prod = s1_mag_reg * RECIP_C;
        h_prod = s1_side_reg.ax * SQRT3_HALF_C;
    end

    // ---- stage 3: remainder, rounded height
    logic                     s3_valid_reg;
    side_t                    s3_side_reg;
    logic signed [RED_W-1:0]  s3_r_reg;
    logic                     s3_neg_reg;
    logic signed [DIFF_W-1:0] s3_dax_reg, s3_day_reg, s3_dbx_reg, s3_dby_reg;

    logic signed [RED_W-1:0]  rem;
    logic signed [HPROD_W-1:0] h_round;
    side_t                    side_h;

    always_comb
    begin
        rem = $signed(RED_W'(s2_mag_reg)) - $signed(RED_W'(s2_q_reg)) * FULL_S;
        h_round = (s2_hprod_reg + HPROD_W'(32768)) >>> 16;
        side_h = s2_side_reg;
        side_h.h = h_round[H_W-1:0];
    end

    // ---- stage 4: remainder correction, sign restore
    logic                     s4_valid_reg;
    side_t                    s4_side_reg;
    logic signed [RED_W-1:0]  s4_r_reg;
    logic signed [DIFF_W-1:0] s4_dax_reg, s4_day_reg, s4_dbx_reg, s4_dby_reg;

    logic signed [RED_W-1:0]  rem_fix, rem_sgn;

    always_comb
    begin
        rem_fix = (s3_r_reg >= FULL_S) ? s3_r_reg - FULL_S : s3_r_reg;
        rem_sgn = s3_neg_reg ? -rem_fix : rem_fix;
    end

    // ---- stage 5: half-turn wrap, quadrant fold
    logic                     s5_valid_reg;
    side_t                    s5_side_reg;
    logic signed [Z_W-1:0]    s5_z_reg;
    logic signed [DIFF_W-1:0] s5_dax_reg, s5_day_reg, s5_dbx_reg, s5_dby_reg;

    logic signed [RED_W-1:0]  r_wrap, r_fold;
    logic                     flip;
    logic signed [Z_W-1:0]    z_val;

    always_comb
    begin
        r_wrap = s4_r_reg;
        if (r_wrap >= HALF_S)
            r_wrap = r_wrap - FULL_S;
        else if (r_wrap < -HALF_S)
            r_wrap = r_wrap + FULL_S;
        flip = 1'b0;
        r_fold = r_wrap;
        if (r_wrap > QUARTER_S)
        begin
            flip = 1'b1;
            r_fold = r_wrap - HALF_S;
        end
        else if (r_wrap < -QUARTER_S)
        begin
            flip = 1'b1;
            r_fold = r_wrap + HALF_S;
        end
        z_val = Z_W'(r_fold) <<< ZSHIFT;
    end

    // ---- stage 6: inverse gain scaling
    logic                     s6_valid_reg;
    side_t                    s6_side_reg;
    logic signed [Z_W-1:0]    s6_z_reg;
    logic signed [CX_W-1:0]   s6_xa_reg, s6_ya_reg, s6_xb_reg, s6_yb_reg;

    // ---- CORDIC
    logic                     c_valid;
    side_t                    c_side;
    logic signed [CX_W-1:0]   c_xa, c_ya, c_xb, c_yb;

    svg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_side   (s6_side_reg),
        .in_xa     (s6_xa_reg),
        .in_ya     (s6_ya_reg),
        .in_xb     (s6_xb_reg),
        .in_yb     (s6_yb_reg),
        .in_z      (s6_z_reg),
        .out_valid (c_valid),
        .out_side  (c_side),
        .out_xa    (c_xa),
        .out_ya    (c_ya),
        .out_xb    (c_xb),
        .out_yb    (c_yb)
    );

    // ---- stage 7: Q16 rounding
    logic                     s7_valid_reg;
    side_t                    s7_side_reg;
    logic signed [RX_W-1:0]   s7_rax_reg, s7_ray_reg, s7_rbx_reg, s7_rby_reg;

    logic signed [CX_W-1:0]   t_xa, t_ya, t_xb, t_yb;

    always_comb
    begin
        t_xa = (c_xa + CX_W'(32768)) >>> 16;
        t_ya = (c_ya + CX_W'(32768)) >>> 16;
        t_xb = (c_xb + CX_W'(32768)) >>> 16;
        t_yb = (c_yb + CX_W'(32768)) >>> 16;
    end

    // ---- stage 8: vertex assembly and saturation
    logic                      fin_valid_reg;
    logic signed [COORD_W-1:0] fin_vx_reg [NVERT];
    logic signed [COORD_W-1:0] fin_vy_reg [NVERT];
    logic [IDX_W-1:0]          fin_last_reg;
    logic                      fin_err_reg;

    logic signed [SUM_W-1:0]   vx_sum [NVERT];
    logic signed [SUM_W-1:0]   vy_sum [NVERT];
    logic signed [SUM_W-1:0]   pxe, pye, axe, aye, bxe, bye, he, halfe;
    logic [IDX_W-1:0]          last_idx;
    logic                      err_now;
    logic                      op_ok;

    always_comb
    begin
        pxe   = SUM_W'(s7_side_reg.px);
        pye   = SUM_W'(s7_side_reg.py);
        axe   = SUM_W'(s7_side_reg.ax);
        aye   = SUM_W'(s7_side_reg.ay);
        bxe   = SUM_W'(s7_side_reg.bx);
        bye   = SUM_W'(s7_side_reg.by);
        he    = SUM_W'(s7_side_reg.h);
        halfe = (axe + SUM_W'(1)) >>> 1;
        for (int k = 0; k < NVERT; k++)
        begin
            vx_sum[k] = pxe;
            vy_sum[k] = pye;
        end
        last_idx = TRI_LAST;
        err_now  = 1'b0;
        op_ok    = 1'b1;
        unique case (s7_side_reg.op)
            OP_DIRECT:
            begin
                vx_sum[1] = axe;
                vy_sum[1] = aye;
                vx_sum[2] = bxe;
                vy_sum[2] = bye;
            end
            OP_OFFSETS:
            begin
                vx_sum[1] = pxe + axe;
                vy_sum[1] = pye + aye;
                vx_sum[2] = pxe + bxe;
                vy_sum[2] = pye + bye;
            end
            OP_ROTATED, OP_ROT_RIGHT:
            begin
                vx_sum[1] = pxe + SUM_W'(s7_rax_reg);
                vy_sum[1] = pye + SUM_W'(s7_ray_reg);
                vx_sum[2] = pxe + SUM_W'(s7_rbx_reg);
                vy_sum[2] = pye + SUM_W'(s7_rby_reg);
            end
            OP_RIGHT:
            begin
                vy_sum[1] = pye + aye;
                vx_sum[2] = pxe + axe;
            end
            OP_EQUI:
            begin
                vx_sum[1] = pxe - halfe;
                vy_sum[1] = pye - he;
                vx_sum[2] = pxe + halfe;
                vy_sum[2] = pye - he;
            end
            OP_RECT:
            begin
                last_idx  = RECT_LAST;
                err_now   = s7_side_reg.ax[COORD_W-1] | s7_side_reg.ay[COORD_W-1];
                vy_sum[1] = pye - aye;
                vx_sum[2] = pxe + axe;
                vx_sum[3] = pxe + axe;
                vy_sum[3] = pye - aye;
                vx_sum[4] = pxe + axe;
                vy_sum[5] = pye - aye;
            end
            default:
                op_ok = 1'b0;
        endcase
    end

    // ---- vertex serializer
    logic                      ser_busy_reg;
    logic [IDX_W-1:0]          ser_idx_reg;
    logic [IDX_W-1:0]          ser_last_reg;
    logic                      ser_err_reg;
    logic signed [COORD_W-1:0] ser_vx_reg [NVERT];
    logic signed [COORD_W-1:0] ser_vy_reg [NVERT];

    logic ser_done;
    logic ser_load;
    logic [IDX_W+STRIDE_W-1:0] ofs_full;

    assign ser_done = ser_busy_reg && vtx.ready && (ser_idx_reg == ser_last_reg);
    assign ser_load = fin_valid_reg && (!ser_busy_reg || ser_done);
    assign adv      = !fin_valid_reg || ser_load;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= STRIDE_RESET;
        else if (cfg_we)
            stride_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= req.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= c_valid;
            fin_valid_reg <= s7_valid_reg && op_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= side_in;
            s1_mag_reg  <= ang_abs[MAG_W-1:0];
            s1_neg_reg  <= ang_ext[ANGLE_W];
            s1_dax_reg  <= dax;
            s1_day_reg  <= day;
            s1_dbx_reg  <= dbx;
            s1_dby_reg  <= dby;

            s2_side_reg  <= s1_side_reg;
            s2_mag_reg   <= s1_mag_reg;
            s2_q_reg     <= MAG_W'(q_prod >> RECIP_SH);
            s2_neg_reg   <= s1_neg_reg;
            s2_dax_reg   <= s1_dax_reg;
            s2_day_reg   <= s1_day_reg;
            s2_dbx_reg   <= s1_dbx_reg;
            s2_dby_reg   <= s1_dby_reg;
            s2_hprod_reg <= h_prod;

            s3_side_reg <= side_h;
            s3_r_reg    <= rem;
            s3_neg_reg  <= s2_neg_reg;
            s3_dax_reg  <= s2_dax_reg;
            s3_day_reg  <= s2_day_reg;
            s3_dbx_reg  <= s2_dbx_reg;
            s3_dby_reg  <= s2_dby_reg;

            s4_side_reg <= s3_side_reg;
            s4_r_reg    <= rem_sgn;
            s4_dax_reg  <= s3_dax_reg;
            s4_day_reg  <= s3_day_reg;
            s4_dbx_reg  <= s3_dbx_reg;
            s4_dby_reg  <= s3_dby_reg;

            s5_side_reg <= s4_side_reg;
            s5_z_reg    <= z_val;
            s5_dax_reg  <= flip ? -s4_dax_reg : s4_dax_reg;
            s5_day_reg  <= flip ? -s4_day_reg : s4_day_reg;
            s5_dbx_reg  <= flip ? -s4_dbx_reg : s4_dbx_reg;
            s5_dby_reg  <= flip ? -s4_dby_reg : s4_dby_reg;

            s6_side_reg <= s5_side_reg;
            s6_z_reg    <= s5_z_reg;
            s6_xa_reg   <= s5_dax_reg * INV_GAIN_C;
            s6_ya_reg   <= s5_day_reg * INV_GAIN_C;
            s6_xb_reg   <= s5_dbx_reg * INV_GAIN_C;
            s6_yb_reg   <= s5_dby_reg * INV_GAIN_C;

            s7_side_reg <= c_side;
            s7_rax_reg  <= t_xa[RX_W-1:0];
            s7_ray_reg  <= t_ya[RX_W-1:0];
            s7_rbx_reg  <= t_xb[RX_W-1:0];
            s7_rby_reg  <= t_yb[RX_W-1:0];

            for (int k = 0; k < NVERT; k++)
            begin
                fin_vx_reg[k] <= sat_coord(vx_sum[k]);
                fin_vy_reg[k] <= sat_coord(vy_sum[k]);
            end
            fin_last_reg <= last_idx;
            fin_err_reg  <= err_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_busy_reg <= 1'b0;
            ser_idx_reg  <= '0;
        end
        else if (ser_load)
        begin
            ser_busy_reg <= 1'b1;
            ser_idx_reg  <= '0;
        end
        else if (ser_done)
            ser_busy_reg <= 1'b0;
        else if (ser_busy_reg && vtx.ready)
            ser_idx_reg <= ser_idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_vx_reg   <= fin_vx_reg;
            ser_vy_reg   <= fin_vy_reg;
            ser_last_reg <= fin_last_reg;
            ser_err_reg  <= fin_err_reg;
        end
    end

    assign ofs_full         = ser_idx_reg * stride_reg;
    assign vtx.valid        = ser_busy_reg;
    assign vtx.vertex_x     = ser_vx_reg[ser_idx_reg];
    assign vtx.vertex_y     = ser_vy_reg[ser_idx_reg];
    assign vtx.vertex_index = ser_idx_reg;
    assign vtx.word_offset  = ofs_full[OFS_W-1:0];
    assign vtx.last         = (ser_idx_reg == ser_last_reg);
    assign vtx.size_error   = ser_err_reg;

endmodule

// File: src/svg_checker.sv
// ----------------------------------------------------------------------------
// Shape vertex generator port checker
// Watches the vertex channel for handshake and vertex sequencing rules.
// ----------------------------------------------------------------------------
`include "shape_vertex_generator_unit_macros.svh"

module svg_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [svg_pkg::COORD_W-1:0] vertex_x,
    input logic signed [svg_pkg::COORD_W-1:0] vertex_y,
    input logic [svg_pkg::IDX_W-1:0]          vertex_index,
    input logic                               last
);
    import svg_pkg::*;

    `SVG_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "vertex valid dropped")
    `SVG_ASSERT_NEXT(a_stall_stable, out_valid && !out_ready, $stable(vertex_x) && $stable(vertex_y) && $stable(vertex_index) && $stable(last), "stalled vertex changed")
    `SVG_ASSERT_NEXT(a_index_step, out_valid && out_ready && !last, out_valid && (vertex_index == $past(vertex_index) + IDX_W'(1)), "vertex sequence broken")
    `SVG_ASSERT_IMPL(a_last_pos, out_valid && last, vertex_index == TRI_LAST || vertex_index == RECT_LAST, "last on wrong vertex")

endmodule

bind shape_vertex_generator_unit svg_checker u_svg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (vtx.valid),
    .out_ready    (vtx.ready),
    .vertex_x     (vtx.vertex_x),
    .vertex_y     (vtx.vertex_y),
    .vertex_index (vtx.vertex_index),
    .last         (vtx.last)
);
